>>> rtl/ttw_pkg.sv
`default_nettype none
package ttw_pkg;

    localparam int DIV_LONG_BITS  = 65;
    localparam int DIV_SHORT_BITS = 32;
    localparam int DIV_CNT_W      = 7;

    // configuration register indexes
    localparam logic CFG_TICK_LEN  = 1'b0;
    localparam logic CFG_SLOT_CNT  = 1'b1;

    // input modes
    localparam logic [1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [1:0] MODE_CANCEL   = 2'd1;
    localparam logic [1:0] MODE_TICK     = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SCH_ACK = 2'd0;
    localparam logic [1:0] KIND_CAN_ACK = 2'd1;
    localparam logic [1:0] KIND_EXPIRY  = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_INVALID   = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] slot;
        logic [31:0] rounds;
        logic [31:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_INC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCH_WRITE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_END,
        ST_REPLY
    } state_t;

    typedef enum logic [1:0] {
        DS_TICKS,
        DS_SLOT,
        DS_ROUNDS,
        DS_TNOW
    } div_src_t;

    typedef enum logic [2:0] {
        OS_FULL,
        OS_SCH_OK,
        OS_CAN_BAD,
        OS_CAN_END,
        OS_EXP,
        OS_TICK_END
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     tick_inc;
        logic     div_go;
        logic     div_take;
        logic     sch_write;
        logic     scan_step;
        logic     scan_end;
        logic     out_load;
        div_src_t div_src;
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       cid_zero;
        logic       full;
        logic       cnt_zero;
        logic       div_busy;
        logic       ev_expire;
        logic       pend_valid;
        logic       tick_mode;
        logic       scan_last;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/ttw_ram.sv
`default_nettype none
module ttw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/ttw_div.sv
`default_nettype none
module ttw_div import ttw_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        long_op,
    input  wire logic [64:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             busy,
    output logic      [64:0] quot,
    output logic      [15:0] rem
);

    logic [64:0]          q_reg, q_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          d_reg, d_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [16:0]          trial;
    logic [16:0]          diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, q_reg[64]};
        diff      = trial - {1'b0, d_reg};
        ge        = trial >= {1'b0, d_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = long_op ? dividend : {dividend[31:0], 33'b0};
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = long_op ? DIV_CNT_W'(DIV_LONG_BITS) : DIV_CNT_W'(DIV_SHORT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[63:0], ge};
            rem_next = ge ? diff[15:0] : trial[15:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

>>> rtl/ttw_datapath.sv
`default_nettype none
module ttw_datapath import ttw_pkg::*; #(
    parameter int MAX_TIMERS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       sts,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] delay_amt,
    input  wire logic [31:0] cancel_id,
    input  wire logic [31:0] user_tag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  result_kind,
    output logic      [1:0]  status,
    output logic      [31:0] task_id,
    output logic      [31:0] expired_tag,
    output logic             last
);

    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam int CNT_W = IDX_W + 1;

    logic [15:0]      tick_len_reg, slot_cnt_reg;
    logic [63:0]      tick_now_reg;
    logic [31:0]      id_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] w_reg;
    logic [IDX_W-1:0] rd_reg;
    logic             found_reg;
    logic             tick_mode_reg;
    logic [31:0]      delay_reg, cid_reg, tag_reg;
    logic [31:0]      ticks_m1_reg, rounds_reg;
    logic [15:0]      slot_reg, cur_slot_reg;
    logic             pend_valid_reg;
    logic [31:0]      pend_id_reg, pend_tag_reg;
    logic             out_valid_reg;
    logic [1:0]       kind_reg, stat_reg;
    logic [31:0]      oid_reg, otag_reg;
    logic             last_reg;

    logic [15:0]      tl, sc;
    logic [64:0]      div_dividend;
    logic [15:0]      div_divisor;
    logic             div_long;
    logic             div_busy;
    logic [64:0]      div_quot;
    logic [15:0]      div_rem;
    logic [32:0]      ticks;

    entry_t           ent_rd, ent_wr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             slot_hit, expire, out_free;
    logic [1:0]       o_kind, o_stat;
    logic [31:0]      o_id, o_tag;
    logic             o_last;

    assign tl    = (tick_len_reg == 16'd0) ? 16'd1 : tick_len_reg;
    assign sc    = (slot_cnt_reg == 16'd0) ? 16'd1 : slot_cnt_reg;
    assign ticks = {1'b0, ticks_m1_reg} + 33'd1;

    always_comb
    begin
        div_dividend = '0;
        div_divisor  = sc;
        div_long     = 1'b0;
        case (cmd.div_src)
            DS_TICKS:
            begin
                div_dividend = {33'b0, (delay_reg == 32'd0) ? 32'd0 : delay_reg - 32'd1};
                div_divisor  = tl;
            end
            DS_SLOT:
            begin
                // tick counter plus delay wraps at 64 bits
                div_dividend = {1'b0, tick_now_reg + {31'b0, ticks}};
                div_long     = 1'b1;
            end
            DS_ROUNDS:
            begin
                div_dividend = {33'b0, ticks_m1_reg};
            end
            DS_TNOW:
            begin
                div_dividend = {1'b0, tick_now_reg};
                div_long     = 1'b1;
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    ttw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .long_op  (div_long),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // scan decision on the entry just read
    assign ent_rd   = entry_t'(ram_rdata);
    assign slot_hit = ent_rd.slot == cur_slot_reg;
    assign expire   = tick_mode_reg ? (slot_hit && ent_rd.rounds == 32'd0)
                                    : (!found_reg && ent_rd.id == cid_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        ent_wr    = ent_rd;
        ram_we    = 1'b0;
        ram_waddr = w_reg[IDX_W-1:0];
        if (cmd.sch_write)
        begin
            ent_wr.id     = id_reg;
            ent_wr.slot   = slot_reg;
            ent_wr.rounds = rounds_reg;
            ent_wr.tag    = tag_reg;
            ram_we        = 1'b1;
            ram_waddr     = count_reg[IDX_W-1:0];
        end
        else if (cmd.scan_step && !expire)
        begin
            if (tick_mode_reg && slot_hit)
            begin
                ent_wr.rounds = ent_rd.rounds - 32'd1;
            end
            ram_we = 1'b1;
        end
    end

    ttw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TIMERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(ent_wr)),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    // result formatting
    always_comb
    begin
        o_kind = KIND_NONE;
        o_stat = STAT_OK;
        o_id   = '0;
        o_tag  = '0;
        o_last = 1'b1;
        case (cmd.out_sel)
            OS_FULL:
            begin
                o_kind = KIND_SCH_ACK;
                o_stat = STAT_FULL;
            end
            OS_SCH_OK:
            begin
                o_kind = KIND_SCH_ACK;
                o_id   = id_reg;
            end
            OS_CAN_BAD:
            begin
                o_kind = KIND_CAN_ACK;
                o_stat = STAT_INVALID;
                o_id   = cid_reg;
            end
            OS_CAN_END:
            begin
                o_kind = KIND_CAN_ACK;
                o_stat = found_reg ? STAT_OK : STAT_NOT_FOUND;
                o_id   = cid_reg;
            end
            OS_EXP:
            begin
                o_kind = KIND_EXPIRY;
                o_id   = pend_id_reg;
                o_tag  = pend_tag_reg;
                o_last = 1'b0;
            end
            OS_TICK_END:
            begin
                if (pend_valid_reg)
                begin
                    o_kind = KIND_EXPIRY;
                    o_id   = pend_id_reg;
                    o_tag  = pend_tag_reg;
                end
            end
            default:
            begin
                o_kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg   <= 16'd10;
            slot_cnt_reg   <= 16'd512;
            tick_now_reg   <= '0;
            id_reg         <= 32'd1;
            count_reg      <= '0;
            w_reg          <= '0;
            rd_reg         <= '0;
            found_reg      <= 1'b0;
            tick_mode_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_TICK_LEN)
                begin
                    tick_len_reg <= cfg_data;
                end
                else
                begin
                    slot_cnt_reg <= cfg_data;
                end
            end
            if (cmd.accept)
            begin
                tick_mode_reg <= mode == MODE_TICK;
                w_reg         <= '0;
                rd_reg        <= '0;
                found_reg     <= 1'b0;
            end
            if (cmd.tick_inc)
            begin
                tick_now_reg <= tick_now_reg + 64'd1;
            end
            if (cmd.sch_write)
            begin
                count_reg <= count_reg + 1'b1;
                id_reg    <= (id_reg == 32'hFFFF_FFFF) ? 32'd1 : id_reg + 32'd1;
            end
            if (cmd.scan_step)
            begin
                rd_reg <= rd_reg + 1'b1;
                if (!expire)
                begin
                    w_reg <= w_reg + 1'b1;
                end
                else if (tick_mode_reg)
                begin
                    pend_valid_reg <= 1'b1;
                end
                else
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.scan_end)
            begin
                count_reg      <= w_reg;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            delay_reg <= delay_amt;
            cid_reg   <= cancel_id;
            tag_reg   <= user_tag;
        end
        if (cmd.div_take)
        begin
            case (cmd.div_src)
                DS_TICKS:  ticks_m1_reg <= div_quot[31:0];
                DS_SLOT:   slot_reg     <= div_rem;
                DS_ROUNDS: rounds_reg   <= div_quot[31:0];
                DS_TNOW:   cur_slot_reg <= div_rem;
                default:   slot_reg     <= div_rem;
            endcase
        end
        if (cmd.scan_step && expire && tick_mode_reg)
        begin
            pend_id_reg  <= ent_rd.id;
            pend_tag_reg <= ent_rd.tag;
        end
        if (cmd.out_load)
        begin
            kind_reg <= o_kind;
            stat_reg <= o_stat;
            oid_reg  <= o_id;
            otag_reg <= o_tag;
            last_reg <= o_last;
        end
    end

    always_comb
    begin
        sts.mode       = mode;
        sts.cid_zero   = cancel_id == 32'd0;
        sts.full       = count_reg == CNT_W'(MAX_TIMERS);
        sts.cnt_zero   = count_reg == '0;
        sts.div_busy   = div_busy;
        sts.ev_expire  = expire;
        sts.pend_valid = pend_valid_reg;
        sts.tick_mode  = tick_mode_reg;
        sts.scan_last  = ({1'b0, rd_reg} + CNT_W'(1)) == count_reg;
        sts.out_free   = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign status      = stat_reg;
    assign task_id     = oid_reg;
    assign expired_tag = otag_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

>>> rtl/ttw_ctrl.sv
`default_nettype none
module ttw_ctrl import ttw_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    state_t   state_reg, state_next;
    div_src_t src_reg, src_next;
    out_sel_t sel_reg, sel_next;
    logic     ev_wait;

    // an expiry displaces the held one, which needs the output register
    assign ev_wait = sts.tick_mode && sts.ev_expire && sts.pend_valid && !sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (sts.mode)
                        MODE_SCHEDULE:
                        begin
                            if (sts.full)
                            begin
                                sel_next   = OS_FULL;
                                state_next = ST_REPLY;
                            end
                            else
                            begin
                                src_next   = DS_TICKS;
                                state_next = ST_DIV_GO;
                            end
                        end
                        MODE_CANCEL:
                        begin
                            if (sts.cid_zero)
                            begin
                                sel_next   = OS_CAN_BAD;
                                state_next = ST_REPLY;
                            end
                            else
                            begin
                                state_next = sts.cnt_zero ? ST_SCAN_END : ST_SCAN_RD;
                            end
                        end
                        MODE_TICK:
                        begin
                            state_next = ST_TICK_INC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK_INC:
            begin
                src_next   = DS_TNOW;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    case (src_reg)
                        DS_TICKS:
                        begin
                            src_next   = DS_SLOT;
                            state_next = ST_DIV_GO;
                        end
                        DS_SLOT:
                        begin
                            src_next   = DS_ROUNDS;
                            state_next = ST_DIV_GO;
                        end
                        DS_ROUNDS:
                        begin
                            state_next = ST_SCH_WRITE;
                        end
                        default:
                        begin
                            state_next = sts.cnt_zero ? ST_SCAN_END : ST_SCAN_RD;
                        end
                    endcase
                end
            end
            ST_SCH_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (!ev_wait)
                begin
                    state_next = sts.scan_last ? ST_SCAN_END : ST_SCAN_RD;
                end
            end
            ST_SCAN_END, ST_REPLY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_src = src_reg;
        cmd.out_sel = sel_reg;
        in_stall    = state_reg != ST_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
            end
            ST_TICK_INC:
            begin
                cmd.tick_inc = 1'b1;
            end
            ST_DIV_GO:
            begin
                cmd.div_go = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                cmd.div_take = !sts.div_busy;
            end
            ST_SCH_WRITE:
            begin
                cmd.out_sel   = OS_SCH_OK;
                cmd.sch_write = sts.out_free;
                cmd.out_load  = sts.out_free;
            end
            ST_SCAN_EV:
            begin
                cmd.out_sel   = OS_EXP;
                cmd.scan_step = !ev_wait;
                cmd.out_load  = !ev_wait && sts.tick_mode && sts.ev_expire && sts.pend_valid;
            end
            ST_SCAN_END:
            begin
                cmd.out_sel  = sts.tick_mode ? OS_TICK_END : OS_CAN_END;
                cmd.scan_end = sts.out_free;
                cmd.out_load = sts.out_free;
            end
            ST_REPLY:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            src_reg   <= DS_TICKS;
            sel_reg   <= OS_FULL;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            sel_reg   <= sel_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/timing_wheel_timer_engine_unit.sv
`default_nettype none
// Channel   Handshake                Payload
// request   in_valid / in_stall      mode, delay_amt, cancel_id, user_tag
// result    out_valid / out_stall    result_kind, status, task_id, expired_tag, last
// config    cfg_write                cfg_index, cfg_data
//
// One request at a time. Schedule: three passes of the bit-serial divider
// (32-, 65- and 32-bit quotients). Cancel: a scan that visits each table
// entry through a registered RAM read. Tick: an increment, a 65-bit divide
// for the current slot, then the same scan of each table entry.
// Reset: async, active low; table holds no entries, tick zero, next id one.
// A stalled result holds the engine only where another result must go out.
module timing_wheel_timer_engine_unit import ttw_pkg::*; #(
    parameter int MAX_TIMERS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] delay_amt,
    input  wire logic [31:0] cancel_id,
    input  wire logic [31:0] user_tag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  result_kind,
    output logic      [1:0]  status,
    output logic      [31:0] task_id,
    output logic      [31:0] expired_tag,
    output logic             last,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // sequencer: walks request phases, issues datapath commands
    ttw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table RAM, divider, tick/id counters, result register
    ttw_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .delay_amt   (delay_amt),
        .cancel_id   (cancel_id),
        .user_tag    (user_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .status      (status),
        .task_id     (task_id),
        .expired_tag (expired_tag),
        .last        (last)
    );

endmodule
`default_nettype wire
